[rtl/dlsp_pkg.sv]
// Shared types and constants of the lattice shortest-path engine.
`timescale 1ns / 1ps

package dlsp_pkg;

  // Fixed field widths of the stream beats
  localparam int NODE_W      = 6;
  localparam int WEIGHT_W    = 16;
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int OUT_COST_W  = 32;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // Request kinds carried on in_tuser
  typedef enum logic [REQ_W-1:0] {
    REQ_NEW    = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_EDGE   = 2'd2,
    REQ_PATH   = 2'd3
  } req_t;

  // Result status carried on out_tuser
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD     = 2'd1,
    STAT_UNREACH = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_RELAX,
    S_WALK,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_t;

  // Decision flags from the relax unit
  typedef struct packed {
    logic src_inf;
    logic take;
  } relax_flags_t;

endpackage

[rtl/dlsp_relax.sv]
// Saturating edge relaxation: source cost plus weight against target cost.
`timescale 1ns / 1ps

module dlsp_relax #(
  parameter int COST_BITS = 32
) (
  input  logic [COST_BITS-1:0]        src_cost,
  input  logic [COST_BITS-1:0]        dst_cost,
  input  logic [dlsp_pkg::WEIGHT_W-1:0] weight,
  output logic [COST_BITS-1:0]        sum,
  output dlsp_pkg::relax_flags_t      flags
);

  localparam int RAW_W = COST_BITS + 1;
  localparam logic [COST_BITS-1:0] INF = '1;
  localparam logic [COST_BITS-1:0] SAT = INF - COST_BITS'(1);

  logic [RAW_W-1:0] raw;

  // Add with one carry bit, clamp finite sums just below infinity
  always_comb begin
    raw = {1'b0, src_cost} + RAW_W'(weight);
    if (raw >= {1'b0, INF}) begin
      sum = SAT;
    end else begin
      sum = raw[COST_BITS-1:0];
    end
    flags.src_inf = (src_cost == INF);
    flags.take    = !flags.src_inf && (sum < dst_cost);
  end

endmodule

[rtl/dag_lattice_shortest_path_top.sv]
// Top level of the lattice shortest-path engine: sequencer and vertex memories.
//
//  channel | direction | tdata (low bit up)             | tuser      | tlast
//  in_     | slave     | start_node, end_node, weight   | req_type   | -
//  out_    | master    | path_node, path_cost           | status     | last
//
// New graph and append are done on acceptance; add edge does a cost memory read,
// then add-compare-write. A path does a predecessor walk on the predecessor
// memory port, then a trace readout. After reset the init state writes the
// root entry before the first beat is taken.
// in_tready drops while a request is in progress and while the output register
// holds a beat that is not being taken.
`timescale 1ns / 1ps

module dag_lattice_shortest_path_top #(
  parameter int MAX_VERTICES = 64,
  parameter int COST_BITS    = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // start_node [5:0], end_node [11:6], weight [27:12], zero fill
  input  logic [dlsp_pkg::IN_TDATA_W-1:0]    in_tdata,
  // req_type [1:0]
  input  logic [dlsp_pkg::REQ_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // path_node [5:0], path_cost [37:6], zero fill
  output logic [dlsp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // status [1:0]
  output logic [dlsp_pkg::STATUS_W-1:0]      out_tuser,
  output logic                               out_tlast
);

  localparam int NODE_W = dlsp_pkg::NODE_W;
  localparam int IDX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int CMP_W  = NODE_W + 1;
  localparam int EXT_W  = (COST_BITS > dlsp_pkg::OUT_COST_W) ? COST_BITS
                                                             : dlsp_pkg::OUT_COST_W;
  localparam logic [COST_BITS-1:0] INF = '1;

  // Vertex memories: cost, {valid, predecessor}, and the trace stack
  logic [COST_BITS-1:0] cost_mem  [MAX_VERTICES];
  logic [NODE_W:0]      pred_mem  [MAX_VERTICES];
  logic [NODE_W-1:0]    trace_mem [MAX_VERTICES];

  dlsp_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]  vc_r, vc_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  logic [NODE_W-1:0]            s_r, e_r;
  logic [dlsp_pkg::WEIGHT_W-1:0] w_r;
  logic [COST_BITS-1:0]         cost_a_r, cost_b_r;
  logic [NODE_W:0]              pred_rd_r;
  logic [NODE_W-1:0]            trace_rd_r;

  logic                          out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]             out_node_r;
  logic [dlsp_pkg::OUT_COST_W-1:0] out_cost_r;
  dlsp_pkg::status_t             out_status_r;
  logic                          out_last_r;

  // Memory port controls
  logic                 cost_we;
  logic [IDX_W-1:0]     cost_waddr;
  logic [COST_BITS-1:0] cost_wdata;
  logic                 pred_we;
  logic [IDX_W-1:0]     pred_waddr;
  logic [NODE_W:0]      pred_wdata;
  logic                 pred_re;
  logic [IDX_W-1:0]     pred_raddr;
  logic                 trace_we;
  logic [IDX_W-1:0]     trace_waddr;
  logic [NODE_W-1:0]    trace_wdata;
  logic                 trace_re;
  logic [IDX_W-1:0]     trace_raddr;

  // Output load controls
  logic                          out_ld;
  logic [NODE_W-1:0]             ld_node;
  logic [dlsp_pkg::OUT_COST_W-1:0] ld_cost;
  dlsp_pkg::status_t             ld_status;
  logic                          ld_last;

  // Input decode
  dlsp_pkg::req_t               in_req;
  logic [NODE_W-1:0]            in_s, in_e;
  logic                         in_fire, out_free;
  logic                         s_out, e_out, full, edge_bad, path_bad;

  // Relax unit and end cost as shown on the output
  logic [COST_BITS-1:0]           relax_sum;
  dlsp_pkg::relax_flags_t         relax_flags;
  logic [EXT_W-1:0]               cost_ext;
  logic [dlsp_pkg::OUT_COST_W-1:0] path_cost;

  assign in_req  = dlsp_pkg::req_t'(in_tuser);
  assign in_s    = in_tdata[5:0];
  assign in_e    = in_tdata[11:6];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == dlsp_pkg::S_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;

  // Range checks against the live vertex count
  assign s_out    = CMP_W'(in_s) >= CMP_W'(vc_r);
  assign e_out    = CMP_W'(in_e) >= CMP_W'(vc_r);
  assign full     = (vc_r == CNT_W'(MAX_VERTICES));
  assign edge_bad = s_out || e_out || (in_e <= in_s);
  assign path_bad = s_out || e_out || (in_s > in_e);

  assign cost_ext  = EXT_W'(cost_b_r);
  assign path_cost = (cost_b_r == INF) ? '1 : cost_ext[dlsp_pkg::OUT_COST_W-1:0];

  dlsp_relax #(
    .COST_BITS (COST_BITS)
  ) u_relax (
    .src_cost (cost_a_r),
    .dst_cost (cost_b_r),
    .weight   (w_r),
    .sum      (relax_sum),
    .flags    (relax_flags)
  );

  // Sequencer: next state, memory accesses, result loads
  always_comb begin
    state_nxt   = state_r;
    vc_nxt      = vc_r;
    node_nxt    = node_r;
    n_nxt       = n_r;
    idx_nxt     = idx_r;
    cost_we     = 1'b0;
    cost_waddr  = '0;
    cost_wdata  = '0;
    pred_we     = 1'b0;
    pred_waddr  = '0;
    pred_wdata  = '0;
    pred_re     = 1'b0;
    pred_raddr  = in_e[IDX_W-1:0];
    trace_we    = 1'b0;
    trace_waddr = n_r[IDX_W-1:0];
    trace_wdata = node_r;
    trace_re    = 1'b0;
    trace_raddr = idx_r;
    out_ld      = 1'b0;
    ld_node     = '0;
    ld_cost     = '0;
    ld_status   = dlsp_pkg::STAT_BAD;
    ld_last     = 1'b1;

    case (state_r)
      dlsp_pkg::S_INIT: begin
        // write the root entry
        cost_we   = 1'b1;
        pred_we   = 1'b1;
        state_nxt = dlsp_pkg::S_IDLE;
      end

      dlsp_pkg::S_IDLE: begin
        if (in_fire) begin
          case (in_req)
            dlsp_pkg::REQ_NEW: begin
              cost_we = 1'b1;
              pred_we = 1'b1;
              vc_nxt  = CNT_W'(1);
            end
            dlsp_pkg::REQ_APPEND: begin
              if (full) begin
                out_ld = 1'b1;
              end else begin
                cost_we    = 1'b1;
                cost_waddr = vc_r[IDX_W-1:0];
                cost_wdata = INF;
                pred_we    = 1'b1;
                pred_waddr = vc_r[IDX_W-1:0];
                vc_nxt     = vc_r + CNT_W'(1);
              end
            end
            dlsp_pkg::REQ_EDGE: begin
              if (edge_bad) begin
                out_ld = 1'b1;
              end else begin
                state_nxt = dlsp_pkg::S_RELAX;
              end
            end
            dlsp_pkg::REQ_PATH: begin
              if (path_bad) begin
                out_ld = 1'b1;
              end else begin
                pred_re   = 1'b1;
                node_nxt  = in_e;
                n_nxt     = '0;
                state_nxt = dlsp_pkg::S_WALK;
              end
            end
            default: ;
          endcase
        end
      end

      dlsp_pkg::S_RELAX: begin
        // write back a strictly smaller cost with its predecessor
        if (relax_flags.take) begin
          cost_we    = 1'b1;
          cost_waddr = e_r[IDX_W-1:0];
          cost_wdata = relax_sum;
          pred_we    = 1'b1;
          pred_waddr = e_r[IDX_W-1:0];
          pred_wdata = {1'b1, s_r};
        end
        state_nxt = dlsp_pkg::S_IDLE;
      end

      dlsp_pkg::S_WALK: begin
        // pred_rd_r holds the entry of node_r; push node_r and follow it, or stop at the start or when unreachable
        if (node_r == s_r) begin
          trace_we  = 1'b1;
          n_nxt     = n_r + CNT_W'(1);
          idx_nxt   = n_r[IDX_W-1:0];
          state_nxt = dlsp_pkg::S_EMIT_RD;
        end else if ((node_r < s_r) || !pred_rd_r[NODE_W] ||
                     (n_r >= CNT_W'(MAX_VERTICES - 1))) begin
          out_ld    = 1'b1;
          ld_cost   = '1;
          ld_status = dlsp_pkg::STAT_UNREACH;
          state_nxt = dlsp_pkg::S_IDLE;
        end else begin
          trace_we   = 1'b1;
          n_nxt      = n_r + CNT_W'(1);
          node_nxt   = pred_rd_r[NODE_W-1:0];
          pred_re    = 1'b1;
          pred_raddr = pred_rd_r[IDX_W-1:0];
        end
      end

      dlsp_pkg::S_EMIT_RD: begin
        trace_re  = 1'b1;
        state_nxt = dlsp_pkg::S_EMIT_OUT;
      end

      dlsp_pkg::S_EMIT_OUT: begin
        // pop the stack, one beat per cycle while the sink takes them
        if (out_free) begin
          out_ld    = 1'b1;
          ld_node   = trace_rd_r;
          ld_cost   = path_cost;
          ld_status = dlsp_pkg::STAT_OK;
          ld_last   = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = dlsp_pkg::S_IDLE;
          end else begin
            idx_nxt     = idx_r - IDX_W'(1);
            trace_re    = 1'b1;
            trace_raddr = idx_r - IDX_W'(1);
          end
        end
      end

      default: state_nxt = dlsp_pkg::S_IDLE;
    endcase

    out_valid_nxt = (out_valid_r && !out_tready) || out_ld;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dlsp_pkg::S_INIT;
      vc_r        <= CNT_W'(1);
      node_r      <= '0;
      n_r         <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vc_r        <= vc_nxt;
      node_r      <= node_nxt;
      n_r         <= n_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the request payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_r <= in_s;
      e_r <= in_e;
      w_r <= in_tdata[27:12];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_node_r   <= ld_node;
      out_cost_r   <= ld_cost;
      out_status_r <= ld_status;
      out_last_r   <= ld_last;
    end
  end

  // Cost memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[cost_waddr] <= cost_wdata;
    end
    if (in_fire) begin
      cost_a_r <= cost_mem[in_s[IDX_W-1:0]];
      cost_b_r <= cost_mem[in_e[IDX_W-1:0]];
    end
  end

  // Predecessor memory
  always_ff @(posedge clk) begin
    if (pred_we) begin
      pred_mem[pred_waddr] <= pred_wdata;
    end
    if (pred_re) begin
      pred_rd_r <= pred_mem[pred_raddr];
    end
  end

  // Trace stack memory
  always_ff @(posedge clk) begin
    if (trace_we) begin
      trace_mem[trace_waddr] <= trace_wdata;
    end
    if (trace_re) begin
      trace_rd_r <= trace_mem[trace_raddr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_cost_r, out_node_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

[rtl/dlsp_checker.sv]
// Port-level checks of the lattice shortest-path engine, bound to the top level.
`timescale 1ns / 1ps

module dlsp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [dlsp_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [dlsp_pkg::REQ_W-1:0]       in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [dlsp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [dlsp_pkg::STATUS_W-1:0]    out_tuser,
  input logic                             out_tlast
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // A rejected request gives a single zero beat
  a_bad_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == dlsp_pkg::STAT_BAD) |-> out_tlast && (out_tdata == '0))
    else $error("bad-request beat malformed");

  // An unreachable end gives node 0, all-ones cost, last
  a_unreach_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == dlsp_pkg::STAT_UNREACH) |->
      out_tlast && (out_tdata[5:0] == '0) && (out_tdata[37:6] == '1))
    else $error("unreachable beat malformed");

  // No status code beyond unreachable
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == dlsp_pkg::STAT_OK) || (out_tuser == dlsp_pkg::STAT_BAD) ||
                   (out_tuser == dlsp_pkg::STAT_UNREACH))
    else $error("unknown status code");

endmodule

bind dag_lattice_shortest_path_top dlsp_checker u_dlsp_checker (.*);

[test/tb_dag_lattice_shortest_path_top.sv]
// Testbench for the lattice shortest-path engine: directed and random requests against a predictor.
`timescale 1ns / 1ps

module tb_dag_lattice_shortest_path_top;

  localparam int NODE_W      = dlsp_pkg::NODE_W;
  localparam int WEIGHT_W    = dlsp_pkg::WEIGHT_W;
  localparam int STATUS_W    = dlsp_pkg::STATUS_W;
  localparam int OUT_COST_W  = dlsp_pkg::OUT_COST_W;
  localparam int VMAX        = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEM_TARGET = 300;
  localparam int QUIET_FROM  = 250;
  localparam int DRAIN_WAIT  = 150;
  localparam logic [OUT_COST_W-1:0] COST_INF = '1;

  // One expected result beat
  typedef struct {
    logic [NODE_W-1:0]     node;
    logic [OUT_COST_W-1:0] cost;
    dlsp_pkg::status_t     status;
    logic                  last;
  } path_beat_t;

  // Lattice predictor plus the queue of result beats it still owes
  class lattice_scoreboard;
    logic [OUT_COST_W-1:0] vert_cost [VMAX];
    logic [NODE_W-1:0]     vert_pred [VMAX];
    bit                    vert_linked [VMAX];
    int unsigned           vcount;
    path_beat_t            beats_due [$];
    int errors, beats_checked, paths_found, bad_replies, unreach_replies;

    function void clear_graph();
      vcount         = 1;
      vert_cost[0]   = '0;
      vert_linked[0] = 1'b0;
    endfunction

    function void expect_beat(input logic [NODE_W-1:0] node,
                              input logic [OUT_COST_W-1:0] cost,
                              input dlsp_pkg::status_t st, input logic last);
      path_beat_t b;
      b.node    = node;
      b.cost    = cost;
      b.status  = st;
      b.last    = last;
      beats_due = {beats_due, b};
    endfunction

    // Apply one accepted request to the lattice and queue its result beats
    function void note_request(input dlsp_pkg::req_t req, input logic [NODE_W-1:0] s,
                               input logic [NODE_W-1:0] e,
                               input logic [WEIGHT_W-1:0] w);
      logic [OUT_COST_W-1:0] src_cost, sum, total;
      logic [NODE_W-1:0]     node;
      logic [NODE_W-1:0]     trail [VMAX];
      int                    n;
      bit                    broken;
      case (req)
        dlsp_pkg::REQ_NEW: begin
          clear_graph();
        end
        dlsp_pkg::REQ_APPEND: begin
          if (vcount >= VMAX) begin
            expect_beat('0, '0, dlsp_pkg::STAT_BAD, 1'b1);
            bad_replies++;
          end else begin
            vert_cost[vcount]   = COST_INF;
            vert_linked[vcount] = 1'b0;
            vcount++;
          end
        end
        dlsp_pkg::REQ_EDGE: begin
          if (s >= vcount || e >= vcount || e <= s) begin
            expect_beat('0, '0, dlsp_pkg::STAT_BAD, 1'b1);
            bad_replies++;
          end else begin
            src_cost = vert_cost[s];
            // an unreached source never relaxes; sums saturate one below infinity
            if (src_cost != COST_INF) begin
              if ({16'd0, w} >= COST_INF - src_cost) sum = COST_INF - 1;
              else sum = src_cost + w;
              if (sum < vert_cost[e]) begin
                vert_cost[e]   = sum;
                vert_pred[e]   = s;
                vert_linked[e] = 1'b1;
              end
            end
          end
        end
        default: begin
          if (s >= vcount || e >= vcount || s > e) begin
            expect_beat('0, '0, dlsp_pkg::STAT_BAD, 1'b1);
            bad_replies++;
          end else begin
            // walk predecessors back from the end vertex
            node   = e;
            n      = 0;
            broken = 1'b0;
            while (node != s && !broken) begin
              if (node < s || !vert_linked[node] || n >= VMAX - 1) begin
                broken = 1'b1;
              end else begin
                trail[n] = node;
                n++;
                node = vert_pred[node];
              end
            end
            if (broken) begin
              expect_beat('0, COST_INF, dlsp_pkg::STAT_UNREACH, 1'b1);
              unreach_replies++;
            end else begin
              trail[n] = s;
              n++;
              total = vert_cost[e];
              for (int k = 0; k < n; k++)
                expect_beat(trail[n-1-k], total, dlsp_pkg::STAT_OK, k == n - 1);
              paths_found++;
            end
          end
        end
      endcase
    endfunction

    // Compare one accepted result beat with the oldest owed beat
    function void check_beat(input logic [NODE_W-1:0] node,
                             input logic [OUT_COST_W-1:0] cost,
                             input logic [STATUS_W-1:0] st, input logic last);
      path_beat_t b;
      beats_checked++;
      if (beats_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none,", $time);
        $display("%0t:   got node %0d cost %h status %0d last %0d",
                 $time, node, cost, st, last);
        return;
      end
      b = beats_due.pop_front();
      if (node !== b.node || cost !== b.cost || st !== b.status || last !== b.last) begin
        errors++;
        $display("%0t: result mismatch, expected node %0d cost %h status %0d last %0d,",
                 $time, b.node, b.cost, b.status, b.last);
        $display("%0t:   got node %0d cost %h status %0d last %0d",
                 $time, node, cost, st, last);
      end
    endfunction
  endclass

  logic                              clk;
  logic                              rst_n;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [dlsp_pkg::IN_TDATA_W-1:0]   in_tdata;
  logic [dlsp_pkg::REQ_W-1:0]        in_tuser;
  logic                              out_tvalid;
  logic                              out_tready;
  logic [dlsp_pkg::OUT_TDATA_W-1:0]  out_tdata;
  logic [STATUS_W-1:0]               out_tuser;
  logic                              out_tlast;

  lattice_scoreboard sb;
  bit                gaps_on;
  bit                stall_on;
  int                items_sent;
  int                stall_left;
  int unsigned       cycles;

  dag_lattice_shortest_path_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still owed", cycles, sb.beats_due.size());
      $display("status: fail");
      $finish;
    end
  end

  // Stall the result channel in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready = 1'b0;
    end else if (stall_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_tready = 1'b0;
    end else begin
      out_tready = 1'b1;
    end
  end

  // Check every result beat taken
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_beat(out_tdata[5:0], out_tdata[37:6], out_tuser, out_tlast);
  end

  // Drive one request beat, hold it until taken, then note it
  task automatic send_beat(input dlsp_pkg::req_t req, input logic [NODE_W-1:0] s,
                           input logic [NODE_W-1:0] e, input logic [WEIGHT_W-1:0] w);
    if (items_sent >= QUIET_FROM) begin
      gaps_on  = 1'b0;
      stall_on = 1'b0;
    end
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = {4'd0, w, e, s};
    do @(posedge clk); while (!in_tready);
    sb.note_request(req, s, e, w);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0, 1:    return WEIGHT_W'($urandom_range(0, 3));
      2:       return '1;
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  // Build one lattice, relax edges over it and ask for paths
  task automatic run_episode(input bit fill_store);
    int unsigned    target;
    int             nedges, npaths;
    logic [NODE_W-1:0] s, e;
    if ($urandom_range(0, 7) != 0)
      send_beat(dlsp_pkg::REQ_NEW, NODE_W'($urandom), NODE_W'($urandom),
                WEIGHT_W'($urandom));
    target = fill_store ? VMAX : $urandom_range(2, 12);
    while (sb.vcount < target)
      send_beat(dlsp_pkg::REQ_APPEND, NODE_W'($urandom), NODE_W'($urandom),
                WEIGHT_W'($urandom));
    if (fill_store) begin
      // appends past a full store, then a cheap chain through every vertex
      repeat (2) send_beat(dlsp_pkg::REQ_APPEND, NODE_W'($urandom), NODE_W'($urandom), '1);
      for (int k = 0; k < VMAX - 1; k++)
        send_beat(dlsp_pkg::REQ_EDGE, NODE_W'(k), NODE_W'(k + 1),
                  WEIGHT_W'($urandom_range(0, 15)));
      send_beat(dlsp_pkg::REQ_PATH, '0, NODE_W'(VMAX - 1), WEIGHT_W'($urandom));
      nedges = 8;
    end else begin
      nedges = $urandom_range(target, 3 * target);
    end
    repeat (nedges) begin
      if ($urandom_range(0, 7) == 0 || sb.vcount < 2) begin
        s = NODE_W'($urandom);
        e = NODE_W'($urandom);
      end else begin
        s = NODE_W'($urandom_range(0, sb.vcount - 2));
        e = NODE_W'($urandom_range(s + 1, sb.vcount - 1));
      end
      send_beat(dlsp_pkg::REQ_EDGE, s, e, pick_weight());
    end
    npaths = $urandom_range(2, 5);
    repeat (npaths) begin
      case ($urandom_range(0, 7))
        0: begin
          s = NODE_W'($urandom);
          e = NODE_W'($urandom);
        end
        1, 2, 3: begin
          s = '0;
          e = NODE_W'($urandom_range(0, sb.vcount - 1));
        end
        default: begin
          e = NODE_W'($urandom_range(0, sb.vcount - 1));
          s = NODE_W'($urandom_range(0, e));
        end
      endcase
      send_beat(dlsp_pkg::REQ_PATH, s, e, WEIGHT_W'($urandom));
    end
  endtask

  initial begin
    bit first_episode;
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = dlsp_pkg::REQ_NEW;
    out_tready = 1'b0;
    stall_left = 0;
    cycles     = 0;
    items_sent = 0;
    gaps_on    = 1'b1;
    stall_on   = 1'b1;
    sb = new;
    sb.clear_graph();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: root-only path, bad indices, unreachable, ties, infinite source
    send_beat(dlsp_pkg::REQ_PATH,   6'd0,  6'd0,  16'd0);
    send_beat(dlsp_pkg::REQ_PATH,   6'd1,  6'd1,  16'd0);
    send_beat(dlsp_pkg::REQ_EDGE,   6'd0,  6'd0,  16'd7);
    send_beat(dlsp_pkg::REQ_APPEND, 6'd63, 6'd63, 16'hffff);
    send_beat(dlsp_pkg::REQ_APPEND, 6'd0,  6'd0,  16'd0);
    send_beat(dlsp_pkg::REQ_PATH,   6'd0,  6'd2,  16'd0);
    send_beat(dlsp_pkg::REQ_PATH,   6'd2,  6'd1,  16'd0);
    send_beat(dlsp_pkg::REQ_EDGE,   6'd1,  6'd2,  16'd5);
    send_beat(dlsp_pkg::REQ_EDGE,   6'd0,  6'd1,  16'hffff);
    send_beat(dlsp_pkg::REQ_EDGE,   6'd1,  6'd2,  16'd0);
    send_beat(dlsp_pkg::REQ_EDGE,   6'd0,  6'd2,  16'hffff);
    send_beat(dlsp_pkg::REQ_EDGE,   6'd2,  6'd1,  16'd1);
    send_beat(dlsp_pkg::REQ_EDGE,   6'd0,  6'd3,  16'd1);
    send_beat(dlsp_pkg::REQ_PATH,   6'd0,  6'd2,  16'd0);
    send_beat(dlsp_pkg::REQ_PATH,   6'd1,  6'd2,  16'd0);
    send_beat(dlsp_pkg::REQ_PATH,   6'd2,  6'd2,  16'd0);
    send_beat(dlsp_pkg::REQ_EDGE,   6'd0,  6'd2,  16'd100);
    send_beat(dlsp_pkg::REQ_PATH,   6'd0,  6'd2,  16'd0);
    send_beat(dlsp_pkg::REQ_PATH,   6'd1,  6'd2,  16'd0);
    send_beat(dlsp_pkg::REQ_APPEND, 6'd0,  6'd0,  16'd0);
    send_beat(dlsp_pkg::REQ_PATH,   6'd3,  6'd3,  16'd0);
    send_beat(dlsp_pkg::REQ_PATH,   6'd0,  6'd63, 16'hffff);
    send_beat(dlsp_pkg::REQ_NEW,    6'd63, 6'd63, 16'hffff);
    send_beat(dlsp_pkg::REQ_PATH,   6'd0,  6'd1,  16'd0);

    // Random lattices; the first one fills the store
    first_episode = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      run_episode(first_episode || $urandom_range(0, 11) == 0);
      first_episode = 1'b0;
    end
    in_tvalid = 1'b0;

    // Drain owed beats, then watch for strays
    while (sb.beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("requests sent %0d, result beats checked %0d, mismatches %0d",
             items_sent, sb.beats_checked, sb.errors);
    $display("paths traced %0d, bad-request replies %0d, unreachable replies %0d",
             sb.paths_found, sb.bad_replies, sb.unreach_replies);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/dlsp_pkg.sv
rtl/dlsp_relax.sv
rtl/dag_lattice_shortest_path_top.sv
rtl/dlsp_checker.sv
test/tb_dag_lattice_shortest_path_top.sv
